FILE: src/ntt_twiddle_generator_top_assert.svh
// Assertion macros shared by the twiddle generator RTL.
// Included by the modules that check their own logic; needs no package.
`ifndef NTT_TWIDDLE_GENERATOR_TOP_ASSERT_SVH
`define NTT_TWIDDLE_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NTT_TW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NTT_TW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define NTT_TW_ASSERT(lbl, clk, rst_n, prop, msg)
`define NTT_TW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/ntt_tw_pkg.sv
// Shared widths and register indexes of the twiddle generator.
// Used by ntt_tw_cfg and the top level; depends on nothing.
package ntt_tw_pkg;

	localparam int STAGE_W   = 3;
	localparam int POS_W     = 8;
	localparam int LOG_W     = 4;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULUS  = 3'd0,
		CFG_LOG_SIZE = 3'd1,
		CFG_ORDERING = 3'd2,
		CFG_ROOT     = 3'd3,
		CFG_SCALE    = 3'd4
	} cfg_reg_t;

endpackage

FILE: src/ntt_tw_cfg.sv
// Configuration registers of the twiddle generator, with index decode.
// Depends on ntt_tw_pkg.
module ntt_tw_cfg
	import ntt_tw_pkg::*;
#(
	parameter int MAX_LOG_SIZE = 8,
	parameter int MOD_WIDTH    = 24,
	parameter int LEN_W        = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MOD_WIDTH-1:0] cfg_wdata,
	output logic [MOD_WIDTH-1:0] modulus,
	output logic [LEN_W-1:0]     len,
	output logic                 ordering_mode,
	output logic [MOD_WIDTH-1:0] root,
	output logic [MOD_WIDTH-1:0] scale
);

	logic [MOD_WIDTH-1:0] modulus_q;
	logic [LOG_W-1:0]     log_size_q;
	logic                 ordering_q;
	logic [MOD_WIDTH-1:0] root_q;
	logic [MOD_WIDTH-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_WIDTH'(3329);
			log_size_q <= LOG_W'(7);
			ordering_q <= 1'b0;
			root_q     <= MOD_WIDTH'(17);
			scale_q    <= MOD_WIDTH'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MODULUS:  modulus_q  <= cfg_wdata;
				CFG_LOG_SIZE: log_size_q <= cfg_wdata[LOG_W-1:0];
				CFG_ORDERING: ordering_q <= cfg_wdata[0];
				CFG_ROOT:     root_q     <= cfg_wdata;
				CFG_SCALE:    scale_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The number of stages in use saturates at the largest supported size.
	always_comb begin
		if (32'(log_size_q) > MAX_LOG_SIZE) begin
			len = LEN_W'(MAX_LOG_SIZE);
		end else begin
			len = LEN_W'(log_size_q);
		end
	end

	assign modulus       = modulus_q;
	assign ordering_mode = ordering_q;
	assign root          = root_q;
	assign scale         = scale_q;

endmodule

FILE: src/ntt_tw_modmul.sv
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// Requires a below q; b may be any value. Depends on the assertion header.
`include "ntt_twiddle_generator_top_assert.svh"
module ntt_tw_modmul #(
	parameter int MOD_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MOD_WIDTH-1:0] a,
	input  logic [MOD_WIDTH-1:0] b,
	input  logic [MOD_WIDTH-1:0] q,
	output logic                 done,
	output logic [MOD_WIDTH-1:0] res
);

	localparam int CNT_W = (MOD_WIDTH > 1) ? $clog2(MOD_WIDTH) : 1;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MOD_WIDTH-1:0] a_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0] q_q;
	logic [MOD_WIDTH-1:0] acc_q;

	logic [MOD_WIDTH:0]   dbl;
	logic [MOD_WIDTH:0]   q_ext;
	logic [MOD_WIDTH:0]   dbl_red;
	logic [MOD_WIDTH:0]   sum;
	logic [MOD_WIDTH-1:0] acc_nxt;

	always_comb begin
		q_ext   = {1'b0, q_q};
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= q_ext) ? dbl - q_ext : dbl;
		sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]} + (b_q[MOD_WIDTH-1] ? {1'b0, a_q} : '0);
		if (sum >= q_ext) begin
			acc_nxt = MOD_WIDTH'(sum - q_ext);
		end else begin
			acc_nxt = sum[MOD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			q_q   <= q;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			b_q   <= {b_q[MOD_WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = acc_q;

	`NTT_TW_ASSERT_ALWAYS(a_busy_done_excl, clk, !arst_n || !(busy_q && done_q),
		"modmul busy and done together")
	`NTT_TW_ASSERT(a_start_when_free, clk, arst_n, start |-> !busy_q,
		"modmul started while busy")
	`NTT_TW_ASSERT(a_result_reduced, clk, arst_n, done_q |-> (acc_q < q_q),
		"modmul result not reduced")

endmodule

FILE: src/ntt_twiddle_generator_top.sv
// Top level of the NTT twiddle generator: sequencer, exponent decode, output word.
// Depends on ntt_tw_pkg, ntt_tw_cfg, ntt_tw_modmul and the assertion header.
//
//  channel  | handshake            | payload
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//  req      | req_valid, req_stall | stage, position
//  rsp      | rsp_valid, rsp_stall | twiddle, range_error
//
// A valid request takes 2 + (L - 1) + popcount(exponent) modular products, each one
// worked out by the bit-serial multiplier one bit per cycle, before the word is handed off.
// A request that is out of range, or meets a zero modulus, goes straight to the output state.
// Reset clears control state only; the output word waits in its register while stalled.
`include "ntt_twiddle_generator_top_assert.svh"
module ntt_twiddle_generator_top
	import ntt_tw_pkg::*;
#(
	parameter int MAX_LOG_SIZE = 8,
	parameter int MOD_WIDTH    = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MOD_WIDTH-1:0] cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [STAGE_W-1:0]   stage,
	input  logic [POS_W-1:0]     position,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [MOD_WIDTH-1:0] twiddle,
	output logic                 range_error
);

	localparam int LEN_W = $clog2(MAX_LOG_SIZE + 1);
	localparam int IDX_W = (MAX_LOG_SIZE > 1) ? $clog2(MAX_LOG_SIZE) : 1;
	localparam int SH_W  = LEN_W + 1;
	localparam int NW    = POS_W + 1;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_REDUCE = 7'b0000010,
		S_NEXT   = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_SQR    = 7'b0010000,
		S_SCALE  = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	logic [MOD_WIDTH-1:0] modulus;
	logic [LEN_W-1:0]     len;
	logic                 ordering_mode;
	logic [MOD_WIDTH-1:0] root;
	logic [MOD_WIDTH-1:0] scale;

	state_t                  state_q, state_nxt;
	logic [LEN_W-1:0]        m_q;
	logic [MAX_LOG_SIZE-1:0] exp_q;
	logic [MOD_WIDTH-1:0]    acc_q;
	logic [MOD_WIDTH-1:0]    pow_q;
	logic                    err_q;
	logic                    rsp_valid_q;
	logic [MOD_WIDTH-1:0]    rsp_twiddle_q;
	logic                    rsp_error_q;

	logic                    mm_start;
	logic [MOD_WIDTH-1:0]    mm_a;
	logic [MOD_WIDTH-1:0]    mm_b;
	logic                    mm_done;
	logic [MOD_WIDTH-1:0]    mm_res;

	logic                    req_fire;
	logic                    req_bad;
	logic                    q_zero;
	logic [MOD_WIDTH-1:0]    one_mod;
	logic [NW-1:0]           run_idx;
	logic [MAX_LOG_SIZE-1:0] run_ext;
	logic [MAX_LOG_SIZE-1:0] pos_ext;
	logic [MAX_LOG_SIZE-1:0] rev_run;
	logic [MAX_LOG_SIZE-1:0] rev_pos;
	logic [SH_W-1:0]         shift;
	logic [MAX_LOG_SIZE-1:0] exp_nxt;
	logic [IDX_W-1:0]        m_idx;
	logic [LEN_W-1:0]        m_inc;
	logic                    out_free;

	ntt_tw_cfg #(
		.MAX_LOG_SIZE(MAX_LOG_SIZE),
		.MOD_WIDTH   (MOD_WIDTH),
		.LEN_W       (LEN_W)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.modulus      (modulus),
		.len          (len),
		.ordering_mode(ordering_mode),
		.root         (root),
		.scale        (scale)
	);

	ntt_tw_modmul #(
		.MOD_WIDTH(MOD_WIDTH)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.a     (mm_a),
		.b     (mm_b),
		.q     (modulus),
		.done  (mm_done),
		.res   (mm_res)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign q_zero    = (modulus == '0);
	assign one_mod   = (modulus > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;
	assign req_bad   = (32'(stage) >= 32'(len)) || ((position >> stage) != '0);
	assign m_idx     = m_q[IDX_W-1:0];
	assign m_inc     = m_q + LEN_W'(1);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// The exponent is a bit reversal over the stages in use, done as a full
	// reversal followed by a right shift.
	always_comb begin
		run_idx = (NW'(1) << stage) + NW'(position);
		run_ext = MAX_LOG_SIZE'(run_idx);
		pos_ext = MAX_LOG_SIZE'(position);
		for (int j = 0; j < MAX_LOG_SIZE; j++) begin
			rev_run[j] = run_ext[MAX_LOG_SIZE-1-j];
			rev_pos[j] = pos_ext[MAX_LOG_SIZE-1-j];
		end
		shift   = SH_W'(MAX_LOG_SIZE) - SH_W'(len);
		exp_nxt = ordering_mode ? (rev_pos >> (shift + SH_W'(1))) : (rev_run >> shift);
	end

	always_comb begin
		state_nxt = state_q;
		mm_start  = 1'b0;
		mm_a      = acc_q;
		mm_b      = pow_q;
		unique case (state_q) inside
			S_IDLE: begin
				if (req_fire) begin
					if (req_bad || q_zero) begin
						state_nxt = S_OUT;
					end else begin
						mm_start  = 1'b1;
						mm_a      = one_mod;
						mm_b      = root;
						state_nxt = S_REDUCE;
					end
				end
			end
			S_REDUCE: begin
				if (mm_done) begin
					state_nxt = S_NEXT;
				end
			end
			S_NEXT: begin
				if (m_q == len) begin
					mm_start  = 1'b1;
					mm_b      = scale;
					state_nxt = S_SCALE;
				end else if (exp_q[m_idx]) begin
					mm_start  = 1'b1;
					state_nxt = S_MUL;
				end else if (m_inc != len) begin
					mm_start  = 1'b1;
					mm_a      = pow_q;
					state_nxt = S_SQR;
				end
			end
			S_MUL, S_SQR: begin
				if (mm_done) begin
					state_nxt = S_NEXT;
				end
			end
			S_SCALE: begin
				if (mm_done) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					acc_q <= (req_bad || q_zero) ? '0 : one_mod;
					err_q <= req_bad;
					exp_q <= exp_nxt;
					m_q   <= '0;
				end
			end
			S_REDUCE: begin
				if (mm_done) begin
					pow_q <= mm_res;
				end
			end
			S_NEXT: begin
				if (m_q != len && !exp_q[m_idx] && m_inc == len) begin
					m_q <= m_inc;
				end
			end
			S_MUL: begin
				if (mm_done) begin
					acc_q        <= mm_res;
					exp_q[m_idx] <= 1'b0;
				end
			end
			S_SQR: begin
				if (mm_done) begin
					pow_q <= mm_res;
					m_q   <= m_inc;
				end
			end
			S_SCALE: begin
				if (mm_done) begin
					acc_q <= mm_res;
				end
			end
			S_OUT: begin
				if (out_free) begin
					rsp_twiddle_q <= acc_q;
					rsp_error_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign twiddle     = rsp_twiddle_q;
	assign range_error = rsp_error_q;

	`NTT_TW_ASSERT(a_accept_leaves_idle, clk, arst_n, req_fire |=> (state_q != S_IDLE),
		"accepted word did not start work")
	`NTT_TW_ASSERT(a_done_in_op, clk, arst_n,
		mm_done |-> (state_q == S_REDUCE || state_q == S_MUL || state_q == S_SQR ||
			state_q == S_SCALE),
		"product finished outside an operation")
	`NTT_TW_ASSERT(a_error_zero, clk, arst_n,
		(rsp_valid_q && rsp_error_q) |-> (rsp_twiddle_q == '0),
		"flagged word carries a nonzero twiddle")
	`NTT_TW_ASSERT(a_start_from_seq, clk, arst_n,
		mm_start |-> (state_q == S_IDLE || state_q == S_NEXT),
		"product started outside a decision state")

endmodule
